// ===== hdl/mes_pkg.sv =====
// ----------------------------------------------------------------------------
// mes_pkg
// Shared types and constants for the track event serializer.
// ----------------------------------------------------------------------------
package mes_pkg;

    // field widths
    localparam int DELTA_W  = 28;
    localparam int GROUP_W  = 7;
    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 4;

    // opcodes of an input beat
    localparam logic OP_EVENT   = 1'b0;
    localparam logic OP_PAYLOAD = 1'b1;

    // status codes
    localparam logic [BYTE_W-1:0] STATUS_RUNNING = 8'h00;
    localparam logic [BYTE_W-1:0] STATUS_META    = 8'hFF;
    localparam logic [BYTE_W-1:0] STATUS_SYSEX   = 8'hF0;

    // continuation flag of a delta byte
    localparam logic VLQ_CONT = 1'b1;
    localparam logic VLQ_END  = 1'b0;

    // channel message kinds (high nibble of status)
    localparam logic [KIND_W-1:0] KIND_NOTE_OFF  = 4'h8;
    localparam logic [KIND_W-1:0] KIND_NOTE_ON   = 4'h9;
    localparam logic [KIND_W-1:0] KIND_POLY_AT   = 4'hA;
    localparam logic [KIND_W-1:0] KIND_CTRL      = 4'hB;
    localparam logic [KIND_W-1:0] KIND_PROGRAM   = 4'hC;
    localparam logic [KIND_W-1:0] KIND_CHAN_AT   = 4'hD;
    localparam logic [KIND_W-1:0] KIND_PITCH     = 4'hE;

    // control from sequencer to delta shifter
    typedef struct packed {
        logic load;
        logic shift;
    } vlq_ctrl_t;

    // status from delta shifter to sequencer
    typedef struct packed {
        logic [GROUP_W-1:0] digit;
        logic               last_group;
    } vlq_stat_t;

endpackage

// ===== hdl/mes_in_if.sv =====
// ----------------------------------------------------------------------------
// mes_in_if
// Input channel: one track event or one meta payload byte per beat.
// ----------------------------------------------------------------------------
interface mes_in_if;

    logic                            valid;
    logic                            ready;
    logic                            opcode;
    logic [mes_pkg::DELTA_W-1:0]     delta_ticks;
    logic [mes_pkg::BYTE_W-1:0]      status;
    logic [mes_pkg::BYTE_W-1:0]      meta_type;
    logic [mes_pkg::BYTE_W-1:0]      meta_length;
    logic [mes_pkg::BYTE_W-1:0]      param_one;
    logic [mes_pkg::BYTE_W-1:0]      param_two;
    logic [mes_pkg::BYTE_W-1:0]      payload_byte;

    modport source (
        output valid, opcode, delta_ticks, status, meta_type, meta_length,
               param_one, param_two, payload_byte,
        input  ready
    );

    modport sink (
        input  valid, opcode, delta_ticks, status, meta_type, meta_length,
               param_one, param_two, payload_byte,
        output ready
    );

endinterface

// ===== hdl/mes_out_if.sv =====
// ----------------------------------------------------------------------------
// mes_out_if
// Output channel: one serialized file byte per beat.
// ----------------------------------------------------------------------------
interface mes_out_if;

    logic                        valid;
    logic                        ready;
    logic [mes_pkg::BYTE_W-1:0]  out_byte;
    logic                        last;
    logic                        event_done;
    logic                        error;

    modport source (
        output valid, out_byte, last, event_done, error,
        input  ready
    );

    modport sink (
        input  valid, out_byte, last, event_done, error,
        output ready
    );

endinterface

// ===== hdl/mes_vlq_shifter.sv =====
// ----------------------------------------------------------------------------
// mes_vlq_shifter
// Delta time shift register: hands out one 7-bit group per shift,
// most significant group first, leading zero groups skipped.
// ----------------------------------------------------------------------------
module mes_vlq_shifter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mes_pkg::vlq_ctrl_t            ctrl,
    input  logic [mes_pkg::DELTA_W-1:0]   delta_ticks,
    output mes_pkg::vlq_stat_t            stat
);
    import mes_pkg::*;

    localparam int CNT_W = 2;

    logic [DELTA_W-1:0] shift_reg;
    logic [DELTA_W-1:0] shift_next;
    logic [CNT_W-1:0]   left_reg;
    logic [CNT_W-1:0]   left_next;

    // left-align the top nonzero group and count the groups
    always_comb
    begin
        shift_next = shift_reg;
        left_next  = left_reg;
        if (ctrl.load)
        begin
            if (delta_ticks[27:21] != '0)
            begin
                shift_next = delta_ticks;
                left_next  = 2'd3;
            end
            else if (delta_ticks[20:14] != '0)
            begin
                shift_next = {delta_ticks[20:0], 7'b0};
                left_next  = 2'd2;
            end
            else if (delta_ticks[13:7] != '0)
            begin
                shift_next = {delta_ticks[13:0], 14'b0};
                left_next  = 2'd1;
            end
            else
            begin
                shift_next = {delta_ticks[6:0], 21'b0};
                left_next  = 2'd0;
            end
        end
        else if (ctrl.shift)
        begin
            shift_next = {shift_reg[DELTA_W-GROUP_W-1:0], {GROUP_W{1'b0}}};
            left_next  = left_reg - 2'd1;
        end
    end

    // group counter is control, the data word needs no reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
        end
        else
        begin
            left_reg <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

    assign stat.digit      = shift_reg[DELTA_W-1:DELTA_W-GROUP_W];
    assign stat.last_group = (left_reg == '0);

endmodule

// ===== hdl/midi_event_serializer.sv =====
// ----------------------------------------------------------------------------
// midi_event_serializer
// Turns track events into the bytes of a track chunk, one byte per beat.
// ----------------------------------------------------------------------------
// Usage:
//   track  (sink)  : one beat per track event (opcode 0) or per meta payload
//                    byte (opcode 1).
//   serial (source): one beat per file byte; last marks the final byte of
//                    an input beat, event_done the end of a whole event,
//                    error an unknown message type or stray payload.
//   An event is taken, then its bytes leave the output register one per
//   cycle while the receiver is ready: delta groups (1 to 4), status
//   unless running, then meta type and length, the channel parameters
//   or nothing for sysex. The delta shifter hands out one 7-bit group per
//   cycle while the receiver is ready. An accepted input beat reaches the
//   serial port through the sequencer state register and the output register.
//   track.ready is high only between items; the next item may be accepted
//   while the final byte of the previous one still waits in the output
//   register.
//   A stalled receiver (serial.ready low) holds the byte in place and
//   freezes the byte states of the sequencer until it is taken.
//   Reset clears running status, the payload count and the halt flag.
//   After an error every input beat returns a single zero byte with error.
// ----------------------------------------------------------------------------
module midi_event_serializer (
    input  logic     clk,
    input  logic     rst_n,
    mes_in_if.sink   track,
    mes_out_if.source serial
);
    import mes_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ONE,
        S_DELTA,
        S_STATUS,
        S_MTYPE,
        S_MLEN,
        S_P1,
        S_P2
    } state_t;

    state_t             state_reg, state_next;
    logic               halted_reg, halted_next;
    logic [BYTE_W-1:0]  run_status_reg, run_status_next;
    logic [BYTE_W-1:0]  payload_left_reg, payload_left_next;
    logic               out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]  out_byte_reg, out_byte_next;
    logic               out_last_reg, out_last_next;
    logic               out_done_reg, out_done_next;
    logic               out_err_reg, out_err_next;

    // fields held for the duration of one item
    logic [BYTE_W-1:0]  status_reg, status_next;
    logic [BYTE_W-1:0]  mtype_reg, mtype_next;
    logic [BYTE_W-1:0]  mlen_reg, mlen_next;
    logic [BYTE_W-1:0]  p1_reg, p1_next;
    logic [BYTE_W-1:0]  p2_reg, p2_next;
    logic [KIND_W-1:0]  kind_reg, kind_next;
    logic [BYTE_W-1:0]  one_byte_reg, one_byte_next;
    logic               one_done_reg, one_done_next;
    logic               one_err_reg, one_err_next;

    logic               out_free;
    logic               do_emit;
    logic [BYTE_W-1:0]  e_byte;
    logic               e_last;
    logic               e_done;
    logic               e_err;

    vlq_ctrl_t          vlq_ctrl;
    vlq_stat_t          vlq_stat;

    mes_vlq_shifter u_vlq (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (vlq_ctrl),
        .delta_ticks (track.delta_ticks),
        .stat        (vlq_stat)
    );

    assign out_free    = !out_valid_reg || serial.ready;
    assign track.ready = (state_reg == S_IDLE);

    // sequencer: take an item, then emit its bytes one per cycle while the output is free
    always_comb
    begin
        state_next        = state_reg;
        halted_next       = halted_reg;
        run_status_next   = run_status_reg;
        payload_left_next = payload_left_reg;
        status_next       = status_reg;
        mtype_next        = mtype_reg;
        mlen_next         = mlen_reg;
        p1_next           = p1_reg;
        p2_next           = p2_reg;
        kind_next         = kind_reg;
        one_byte_next     = one_byte_reg;
        one_done_next     = one_done_reg;
        one_err_next      = one_err_reg;
        vlq_ctrl          = '0;
        do_emit           = 1'b0;
        e_byte            = '0;
        e_last            = 1'b0;
        e_done            = 1'b0;
        e_err             = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (track.valid)
                begin
                    status_next = track.status;
                    mtype_next  = track.meta_type;
                    mlen_next   = track.meta_length;
                    p1_next     = track.param_one;
                    p2_next     = track.param_two;
                    if (halted_reg)
                    begin
                        one_byte_next = '0;
                        one_done_next = 1'b0;
                        one_err_next  = 1'b1;
                        state_next    = S_ONE;
                    end
                    else if (track.opcode == OP_PAYLOAD)
                    begin
                        if (payload_left_reg == '0)
                        begin
                            halted_next   = 1'b1;
                            one_byte_next = '0;
                            one_done_next = 1'b0;
                            one_err_next  = 1'b1;
                        end
                        else
                        begin
                            payload_left_next = payload_left_reg - 8'd1;
                            one_byte_next     = track.payload_byte;
                            one_done_next     = (payload_left_reg == 8'd1);
                            one_err_next      = 1'b0;
                        end
                        state_next = S_ONE;
                    end
                    else
                    begin
                        payload_left_next = '0;
                        vlq_ctrl.load     = 1'b1;
                        if (track.status == STATUS_RUNNING)
                        begin
                            kind_next = run_status_reg[7:4];
                        end
                        else
                        begin
                            kind_next = track.status[7:4];
                        end
                        if (track.status != STATUS_RUNNING &&
                            track.status != STATUS_META &&
                            track.status != STATUS_SYSEX)
                        begin
                            run_status_next = track.status;
                        end
                        if (track.status == STATUS_META)
                        begin
                            payload_left_next = track.meta_length;
                        end
                        state_next = S_DELTA;
                    end
                end
            end

            S_ONE:
            begin
                if (out_free)
                begin
                    do_emit    = 1'b1;
                    e_byte     = one_byte_reg;
                    e_last     = 1'b1;
                    e_done     = one_done_reg;
                    e_err      = one_err_reg;
                    state_next = S_IDLE;
                end
            end

            S_DELTA:
            begin
                if (out_free)
                begin
                    do_emit        = 1'b1;
                    vlq_ctrl.shift = 1'b1;
                    e_byte = {(vlq_stat.last_group ? VLQ_END : VLQ_CONT), vlq_stat.digit};
                    if (vlq_stat.last_group)
                    begin
                        state_next = (status_reg != STATUS_RUNNING) ? S_STATUS : S_P1;
                    end
                end
            end

            S_STATUS:
            begin
                if (out_free)
                begin
                    do_emit = 1'b1;
                    e_byte  = status_reg;
                    if (status_reg == STATUS_META)
                    begin
                        state_next = S_MTYPE;
                    end
                    else if (status_reg == STATUS_SYSEX)
                    begin
                        e_last     = 1'b1;
                        e_done     = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_P1;
                    end
                end
            end

            S_MTYPE:
            begin
                if (out_free)
                begin
                    do_emit    = 1'b1;
                    e_byte     = mtype_reg;
                    state_next = S_MLEN;
                end
            end

            S_MLEN:
            begin
                if (out_free)
                begin
                    do_emit    = 1'b1;
                    e_byte     = mlen_reg;
                    e_last     = 1'b1;
                    e_done     = (mlen_reg == '0);
                    state_next = S_IDLE;
                end
            end

            S_P1:
            begin
                if (out_free)
                begin
                    do_emit = 1'b1;
                    e_byte  = p1_reg;
                    case (kind_reg) inside
                        KIND_NOTE_OFF, KIND_NOTE_ON, KIND_POLY_AT, KIND_CTRL, KIND_PITCH:
                        begin
                            state_next = S_P2;
                        end
                        KIND_PROGRAM, KIND_CHAN_AT:
                        begin
                            e_last     = 1'b1;
                            e_done     = 1'b1;
                            state_next = S_IDLE;
                        end
                        default:
                        begin
                            e_last      = 1'b1;
                            e_err       = 1'b1;
                            halted_next = 1'b1;
                            state_next  = S_IDLE;
                        end
                    endcase
                end
            end

            S_P2:
            begin
                if (out_free)
                begin
                    do_emit    = 1'b1;
                    e_byte     = p2_reg;
                    e_last     = 1'b1;
                    e_done     = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg && !serial.ready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_done_next  = out_done_reg;
        out_err_next   = out_err_reg;
        if (do_emit)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = e_byte;
            out_last_next  = e_last;
            out_done_next  = e_done;
            out_err_next   = e_err;
        end
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            halted_reg       <= 1'b0;
            run_status_reg   <= '0;
            payload_left_reg <= '0;
            out_valid_reg    <= 1'b0;
            out_byte_reg     <= '0;
            out_last_reg     <= 1'b0;
            out_done_reg     <= 1'b0;
            out_err_reg      <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            halted_reg       <= halted_next;
            run_status_reg   <= run_status_next;
            payload_left_reg <= payload_left_next;
            out_valid_reg    <= out_valid_next;
            out_byte_reg     <= out_byte_next;
            out_last_reg     <= out_last_next;
            out_done_reg     <= out_done_next;
            out_err_reg      <= out_err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        mtype_reg    <= mtype_next;
        mlen_reg     <= mlen_next;
        p1_reg       <= p1_next;
        p2_reg       <= p2_next;
        kind_reg     <= kind_next;
        one_byte_reg <= one_byte_next;
        one_done_reg <= one_done_next;
        one_err_reg  <= one_err_next;
    end

    assign serial.valid      = out_valid_reg;
    assign serial.out_byte   = out_byte_reg;
    assign serial.last       = out_last_reg;
    assign serial.event_done = out_done_reg;
    assign serial.error      = out_err_reg;

    // halt is sticky until reset
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt flag cleared without reset");

    // an error byte always closes its input beat
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_err_reg |-> out_last_reg)
        else $error("error byte not marked last");

    // done and error never on the same byte
    a_done_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_done_reg && out_err_reg))
        else $error("event done together with error");

    // the final delta group leaves the delta state
    a_delta_exit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DELTA && do_emit && vlq_stat.last_group |=> state_reg != S_DELTA)
        else $error("sequencer stayed in delta after last group");

    // an accepted payload byte counts the expected payload down by one
    a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
        track.valid && track.ready && track.opcode == OP_PAYLOAD && !halted_reg &&
        payload_left_reg != '0 |=> payload_left_reg == $past(payload_left_reg) - 8'd1)
        else $error("payload count not decremented");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the track event serializer. Track events and
// meta payload beats go in over the track channel with random gaps; an
// internal model encodes each accepted beat into the file bytes it should
// produce (delta groups, status, meta header or channel parameters) and
// every serial beat is checked field by field against that list. The run
// ends with a halting fault and a few beats sent into the halted block.
// ----------------------------------------------------------------------------
module testbench;

    import mes_pkg::*;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int HOLD_CYCLES    = 120;
    localparam int PRESSURE_BEATS = 30;
    localparam int RANDOM_END     = 395;
    localparam int DRAIN_CYCLES   = 16;

    // one track channel beat
    typedef struct packed {
        logic               opcode;
        logic [DELTA_W-1:0] delta_ticks;
        logic [BYTE_W-1:0]  status;
        logic [BYTE_W-1:0]  meta_type;
        logic [BYTE_W-1:0]  meta_length;
        logic [BYTE_W-1:0]  param_one;
        logic [BYTE_W-1:0]  param_two;
        logic [BYTE_W-1:0]  payload_byte;
    } track_beat_t;

    // one serial channel beat
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
        logic              event_done;
        logic              error;
    } serial_beat_t;

    // ------------------------------------------------------------------------
    // encoder model and byte checker
    // ------------------------------------------------------------------------
    class serial_byte_checker;
        logic [BYTE_W-1:0] running_status;
        logic [BYTE_W-1:0] payload_left;
        bit                halted;
        serial_beat_t      expected_bytes[$];
        int                mismatches;
        int                events_noted;
        int                payload_noted;
        int                beats_checked;

        function new();
            running_status = '0;
            payload_left   = '0;
            halted         = 1'b0;
            mismatches     = 0;
            events_noted   = 0;
            payload_noted  = 0;
            beats_checked  = 0;
        endfunction

        task report(input string msg);
            $display("%t mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        // encode one accepted beat into the bytes it must produce
        function void note_event(input track_beat_t it);
            logic [BYTE_W-1:0]  out_bytes[$];
            logic [DELTA_W-1:0] shifted;
            logic [KIND_W-1:0]  kind;
            serial_beat_t       beat;
            bit                 done;
            bit                 fault;
            int                 groups;
            done   = 1'b0;
            fault  = 1'b0;
            groups = 1;
            if (it.opcode == OP_PAYLOAD)
                payload_noted++;
            else
                events_noted++;

            if (halted) begin
                // halted block answers every beat with a single error byte
                out_bytes.push_back('0);
                fault = 1'b1;
            end else if (it.opcode == OP_PAYLOAD) begin
                if (payload_left == 0) begin
                    // stray payload byte
                    out_bytes.push_back('0);
                    fault  = 1'b1;
                    halted = 1'b1;
                end else begin
                    payload_left = payload_left - 1'b1;
                    out_bytes.push_back(it.payload_byte);
                    done = (payload_left == 0);
                end
            end else begin
                // a new event drops whatever payload was still owed
                payload_left = '0;

                // delta time, most significant group first
                while (groups < 4 && (it.delta_ticks >> (GROUP_W * groups)) != 0)
                    groups++;
                for (int g = groups - 1; g >= 0; g--) begin
                    shifted = it.delta_ticks >> (GROUP_W * g);
                    out_bytes.push_back({((g > 0) ? VLQ_CONT : VLQ_END),
                                         shifted[GROUP_W-1:0]});
                end

                if (it.status != STATUS_RUNNING)
                    out_bytes.push_back(it.status);

                if (it.status == STATUS_META) begin
                    out_bytes.push_back(it.meta_type);
                    out_bytes.push_back(it.meta_length);
                    payload_left = it.meta_length;
                    done = (it.meta_length == 0);
                end else if (it.status == STATUS_SYSEX) begin
                    done = 1'b1;
                end else begin
                    // channel path, running status decides the kind
                    if (it.status == STATUS_RUNNING) begin
                        kind = running_status[BYTE_W-1:BYTE_W-KIND_W];
                    end else begin
                        running_status = it.status;
                        kind = it.status[BYTE_W-1:BYTE_W-KIND_W];
                    end
                    out_bytes.push_back(it.param_one);
                    case (kind) inside
                        KIND_NOTE_OFF, KIND_NOTE_ON, KIND_POLY_AT, KIND_CTRL,
                        KIND_PITCH:
                        begin
                            out_bytes.push_back(it.param_two);
                            done = 1'b1;
                        end
                        KIND_PROGRAM, KIND_CHAN_AT:
                        begin
                            done = 1'b1;
                        end
                        default:
                        begin
                            halted = 1'b1;
                            fault  = 1'b1;
                        end
                    endcase
                end
            end

            // flags sit on the final byte only
            for (int i = 0; i < out_bytes.size(); i++) begin
                beat.out_byte   = out_bytes[i];
                beat.last       = (i == out_bytes.size() - 1);
                beat.event_done = beat.last && done;
                beat.error      = beat.last && fault;
                expected_bytes.push_back(beat);
            end
        endfunction

        // compare one serial beat with the oldest expected byte
        task check_byte(input serial_beat_t got);
            serial_beat_t want;
            beats_checked++;
            if (expected_bytes.size() == 0) begin
                report($sformatf("byte %02h arrived with nothing expected", got.out_byte));
            end else begin
                want = expected_bytes.pop_front();
                if (got.out_byte !== want.out_byte)
                    report($sformatf("out_byte %02h, expected %02h",
                                     got.out_byte, want.out_byte));
                if (got.last !== want.last)
                    report($sformatf("last %b, expected %b (byte %02h)",
                                     got.last, want.last, want.out_byte));
                if (got.event_done !== want.event_done)
                    report($sformatf("event_done %b, expected %b (byte %02h)",
                                     got.event_done, want.event_done, want.out_byte));
                if (got.error !== want.error)
                    report($sformatf("error %b, expected %b (byte %02h)",
                                     got.error, want.error, want.out_byte));
            end
        endtask
    endclass

    logic clk;
    logic rst_n;

    mes_in_if  track_ch ();
    mes_out_if serial_ch ();

    midi_event_serializer dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .track  (track_ch),
        .serial (serial_ch)
    );

    serial_byte_checker book = new();

    int cycle_count;
    int items_sent;
    bit hold_request;
    bit pressing;
    bit calm;
    bit quiet_tail;

    // clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // run limit
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d bytes still expected",
                     cycle_count, book.expected_bytes.size());
            $display("[midi_event_serializer] ERROR");
            $finish;
        end
    end

    // beat monitor, results first so a byte never meets its own input
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (serial_ch.valid && serial_ch.ready)
                book.check_byte({serial_ch.out_byte, serial_ch.last,
                                 serial_ch.event_done, serial_ch.error});
            if (track_ch.valid && track_ch.ready)
                book.note_event({track_ch.opcode, track_ch.delta_ticks,
                                 track_ch.status, track_ch.meta_type,
                                 track_ch.meta_length, track_ch.param_one,
                                 track_ch.param_two, track_ch.payload_byte});
        end
    end

    // receiver: random stalls, one long hold-off on request
    initial
    begin
        serial_ch.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_request) begin
                serial_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
                serial_ch.ready = 1'b1;
            end else if (!(calm || quiet_tail) && $urandom_range(0, 5) == 0) begin
                serial_ch.ready = 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
                serial_ch.ready = 1'b1;
            end else begin
                serial_ch.ready = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [DELTA_W-1:0] random_delta();
        int groups;
        groups = $urandom_range(1, 4);
        case (groups)
            1:       return DELTA_W'($urandom_range(0, 'h7F));
            2:       return DELTA_W'($urandom_range('h80, 'h3FFF));
            3:       return DELTA_W'($urandom_range('h4000, 'h1F_FFFF));
            default: return DELTA_W'($urandom_range('h20_0000, 'hFFF_FFFF));
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] random_channel_status();
        logic [KIND_W-1:0] kind;
        kind = KIND_W'($urandom_range(KIND_NOTE_OFF, KIND_PITCH));
        return {kind, 4'($urandom_range(0, 15))};
    endfunction

    // a status whose type is not a known channel message
    function automatic logic [BYTE_W-1:0] unknown_status();
        int nib;
        nib = $urandom_range(0, 8);
        if (nib == 8)
            return {4'hF, 4'($urandom_range(1, 14))};
        else if (nib == 0)
            return {4'h0, 4'($urandom_range(1, 15))};
        else
            return {4'(nib), 4'($urandom_range(0, 15))};
    endfunction

    // track event, unused fields filled with noise
    function automatic track_beat_t make_event(input logic [DELTA_W-1:0] delta,
                                               input logic [BYTE_W-1:0] status,
                                               input logic [BYTE_W-1:0] mtype,
                                               input logic [BYTE_W-1:0] mlen,
                                               input logic [BYTE_W-1:0] p1,
                                               input logic [BYTE_W-1:0] p2);
        track_beat_t it;
        it.opcode       = OP_EVENT;
        it.delta_ticks  = delta;
        it.status       = status;
        it.meta_type    = mtype;
        it.meta_length  = mlen;
        it.param_one    = p1;
        it.param_two    = p2;
        it.payload_byte = BYTE_W'($urandom);
        return it;
    endfunction

    function automatic track_beat_t make_payload(input logic [BYTE_W-1:0] b);
        track_beat_t it;
        it = make_event(DELTA_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
                        BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
        it.opcode       = OP_PAYLOAD;
        it.payload_byte = b;
        return it;
    endfunction

    function automatic track_beat_t random_channel_event(input bit running);
        return make_event(random_delta(),
                          running ? STATUS_RUNNING : random_channel_status(),
                          BYTE_W'($urandom), BYTE_W'($urandom),
                          BYTE_W'($urandom), BYTE_W'($urandom));
    endfunction

    // offer one beat and wait until it is taken
    task automatic send_beat(input track_beat_t it);
        @(negedge clk);
        track_ch.valid        = 1'b1;
        track_ch.opcode       = it.opcode;
        track_ch.delta_ticks  = it.delta_ticks;
        track_ch.status       = it.status;
        track_ch.meta_type    = it.meta_type;
        track_ch.meta_length  = it.meta_length;
        track_ch.param_one    = it.param_one;
        track_ch.param_two    = it.param_two;
        track_ch.payload_byte = it.payload_byte;
        do @(posedge clk); while (!track_ch.ready);
        items_sent++;
    endtask

    // random sender gap between beats
    task automatic sender_pause();
        int gap;
        if (quiet_tail || calm || pressing || $urandom_range(0, 3) != 0)
            return;
        gap = $urandom_range(1, 8);
        @(negedge clk);
        track_ch.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
    endtask

    task automatic send_and_pause(input track_beat_t it);
        send_beat(it);
        sender_pause();
    endtask

    // meta header followed by some or all of its payload
    task automatic send_meta(input logic [BYTE_W-1:0] mlen, input int keep);
        send_and_pause(make_event(random_delta(), STATUS_META, BYTE_W'($urandom),
                                  mlen, BYTE_W'($urandom), BYTE_W'($urandom)));
        for (int i = 0; i < keep; i++)
            send_and_pause(make_payload(BYTE_W'($urandom)));
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int r;
        int mlen;
        int keep;
        rst_n        = 1'b0;
        items_sent   = 0;
        hold_request = 1'b0;
        pressing     = 1'b0;
        calm         = 1'b0;
        quiet_tail   = 1'b0;
        track_ch.valid        = 1'b0;
        track_ch.opcode       = OP_EVENT;
        track_ch.delta_ticks  = '0;
        track_ch.status       = '0;
        track_ch.meta_type    = '0;
        track_ch.meta_length  = '0;
        track_ch.param_one    = '0;
        track_ch.param_two    = '0;
        track_ch.payload_byte = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // directed: delta group boundaries and every message kind
        send_and_pause(make_event(28'h0, 8'h90, 8'h00, 8'h00, 8'h3C, 8'h7F));
        send_and_pause(make_event(28'h7F, 8'h80, 8'hFF, 8'hFF, 8'h00, 8'h00));
        send_and_pause(make_event(28'h80, 8'hA5, 8'h00, 8'h00, 8'hFF, 8'hFF));
        send_and_pause(make_event(28'h3FFF, 8'hB0, 8'h00, 8'h00, 8'h07, 8'h64));
        send_and_pause(make_event(28'h4000, 8'hC3, 8'h00, 8'h00, 8'h15, 8'hAA));
        send_and_pause(make_event(28'h1F_FFFF, 8'hD7, 8'h00, 8'h00, 8'h40, 8'h55));
        send_and_pause(make_event(28'h20_0000, 8'hEF, 8'h00, 8'h00, 8'h00, 8'h40));
        // running status on a pitch bend, widest delta
        send_and_pause(make_event(28'hFFF_FFFF, STATUS_RUNNING, 8'h00, 8'h00,
                                  8'h12, 8'h34));
        send_and_pause(make_event(28'h5, STATUS_SYSEX, 8'h00, 8'h00, 8'h00, 8'h00));
        // empty meta completes on its length byte
        send_and_pause(make_event(28'h0, STATUS_META, 8'h2F, 8'h00, 8'h00, 8'h00));
        // tempo meta with full payload
        send_and_pause(make_event(28'h60, STATUS_META, 8'h51, 8'h03, 8'h00, 8'h00));
        send_and_pause(make_payload(8'h00));
        send_and_pause(make_payload(8'hFF));
        send_and_pause(make_payload(8'hA5));
        // event during payload abandons the rest
        send_and_pause(make_event(28'h10, STATUS_META, 8'h01, 8'h04, 8'h00, 8'h00));
        send_and_pause(make_payload(8'h5A));
        send_and_pause(make_payload(8'h81));
        send_and_pause(make_event(28'h0, 8'hC0, 8'h00, 8'h00, 8'h7F, 8'h00));
        // running status kept across sysex, then a meta run cut short
        send_and_pause(make_event(28'h1, STATUS_SYSEX, 8'h00, 8'h00, 8'h00, 8'h00));
        send_and_pause(make_event(28'h2, STATUS_RUNNING, 8'h00, 8'h00, 8'h33, 8'h99));
        send_and_pause(make_event(28'h3FFF, STATUS_META, 8'hFF, 8'hFF, 8'h00, 8'h00));
        send_and_pause(make_payload(8'h7E));
        send_and_pause(make_event(28'h80, 8'h9F, 8'h00, 8'h00, 8'h01, 8'hFE));

        // random: mostly well-formed events and complete meta runs
        while (items_sent < RANDOM_END) begin
            calm = (items_sent % 60) >= 45;
            if (items_sent >= 120 && items_sent < 120 + PRESSURE_BEATS) begin
                // receiver holds off while the sender keeps offering
                if (!pressing) begin
                    pressing     = 1'b1;
                    hold_request = 1'b1;
                end
                send_and_pause(random_channel_event(1'($urandom_range(0, 1))));
                continue;
            end
            pressing = 1'b0;
            r = $urandom_range(0, 99);
            if (r < 30) begin
                send_and_pause(random_channel_event(1'b0));
            end else if (r < 50) begin
                send_and_pause(random_channel_event(1'b1));
            end else if (r < 60) begin
                send_and_pause(make_event(random_delta(), STATUS_SYSEX,
                                          BYTE_W'($urandom), BYTE_W'($urandom),
                                          BYTE_W'($urandom), BYTE_W'($urandom)));
            end else begin
                if ($urandom_range(0, 4) == 0) begin
                    mlen = $urandom_range(0, 255);
                    keep = $urandom_range(0, (mlen < 6) ? mlen : 6);
                end else begin
                    mlen = $urandom_range(0, 5);
                    keep = ($urandom_range(0, 9) == 0) ? $urandom_range(0, mlen) : mlen;
                end
                send_meta(BYTE_W'(mlen), keep);
            end
        end

        // tail without idling: a few events, one fault, then the halted block
        calm       = 1'b0;
        pressing   = 1'b0;
        quiet_tail = 1'b1;
        repeat (8) send_and_pause(random_channel_event(1'($urandom_range(0, 1))));
        if ($urandom_range(0, 1))
            send_and_pause(make_payload(BYTE_W'($urandom)));
        else
            send_and_pause(make_event(random_delta(), unknown_status(),
                                      BYTE_W'($urandom), BYTE_W'($urandom),
                                      BYTE_W'($urandom), BYTE_W'($urandom)));
        repeat (6) begin
            if ($urandom_range(0, 1))
                send_and_pause(make_payload(BYTE_W'($urandom)));
            else
                send_and_pause(random_channel_event(1'b0));
        end
        @(negedge clk);
        track_ch.valid = 1'b0;

        // drain, then let the pipeline settle
        while (book.expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d track events and %0d payload beats, %0d serial bytes checked",
                 book.events_noted, book.payload_noted, book.beats_checked);
        $display("delta widths 1..4, all message kinds, running status, meta runs, halt");
        if (book.mismatches == 0 && book.expected_bytes.size() == 0)
            $display("[midi_event_serializer] OK");
        else
            $display("[midi_event_serializer] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/mes_pkg.sv
hdl/mes_in_if.sv
hdl/mes_out_if.sv
hdl/mes_vlq_shifter.sv
hdl/midi_event_serializer.sv
tb/testbench.sv
